// File: design/tntg_pkg.sv
// Shared widths, defaults and controller/datapath interface types for the normal/tangent unit.
package tntg_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int UNIT_BITS_DEF  = 16;

    localparam int DIFF_W   = 25;   // coordinate differences
    localparam int PROD_W   = 50;   // one 25x25 product
    localparam int VEC_W    = 52;   // cross / tangent components and det
    localparam int MAG_W    = 51;   // component magnitudes
    localparam int SQ_W     = 31;   // scaled magnitude
    localparam int SUM_W    = 64;   // sum of squares
    localparam int ROOT_W   = 32;   // integer square root
    localparam int REM_W    = 35;   // square root remainder
    localparam int DREM_W   = 32;   // divider remainder
    localparam int SQRT_STEPS = 32;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic       ld_v0;
        logic       ld_v1;
        logic       ld_v2;
        logic       prod_en;
        logic       sum_en;
        logic       nrm_load;
        logic       nrm_sel;
        logic       scale_en;
        logic       sq_en;
        logic [1:0] sq_idx;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       st_nrm;
        logic       st_tan;
    } t_cmd;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic vec_zero;
        logic in_range;
    } t_stat;

endpackage

// File: design/tntg_dp.sv
// Datapath: vertex storage, products, shared vector normalizer (scale, sqrt, divide).
module tntg_dp import tntg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int UNIT_BITS  = UNIT_BITS_DEF
) (
    input  logic                         i_clk,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic signed [COORD_BITS-1:0] i_tex_u,
    input  logic signed [COORD_BITS-1:0] i_tex_v,
    output logic signed [UNIT_BITS-1:0]  o_normal_x,
    output logic signed [UNIT_BITS-1:0]  o_normal_y,
    output logic signed [UNIT_BITS-1:0]  o_normal_z,
    output logic signed [UNIT_BITS-1:0]  o_tangent_x,
    output logic signed [UNIT_BITS-1:0]  o_tangent_y,
    output logic signed [UNIT_BITS-1:0]  o_tangent_z,
    output logic                         o_normal_degenerate,
    output logic                         o_tangent_degenerate
);

    localparam int PRE   = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;
    localparam int NUM_W = UNIT_BITS + 31;

    // floor((a - b) / 2^PRE), kept in 25 bits
    function automatic logic signed [DIFF_W-1:0] delta(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
        d = d >>> PRE;
        return DIFF_W'(d);
    endfunction

    // clamp, saturate positive full scale, restore sign
    function automatic logic [UNIT_BITS-1:0] fmt(
        input logic [UNIT_BITS-1:0] q,
        input logic                 neg
    );
        logic [UNIT_BITS-1:0] h;
        logic [UNIT_BITS-1:0] r;
        h = {1'b1, {(UNIT_BITS-1){1'b0}}};
        r = (q > h) ? h : q;
        if (!neg && r == h) r = h - 1'b1;
        if (neg) r = -r;
        return r;
    endfunction

    logic signed [COORD_BITS-1:0] pin [3];
    logic signed [COORD_BITS-1:0] r_p0 [3], r_p1 [3], r_p2 [3];
    logic signed [COORD_BITS-1:0] r_uv0 [2], r_uv1 [2], r_uv2 [2];

    assign pin[0] = i_pos_x;
    assign pin[1] = i_pos_y;
    assign pin[2] = i_pos_z;

    // vertex capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_v0) begin
            r_p0   <= pin;
            r_uv0[0] <= i_tex_u;
            r_uv0[1] <= i_tex_v;
        end
        if (i_cmd.ld_v1) begin
            r_p1   <= pin;
            r_uv1[0] <= i_tex_u;
            r_uv1[1] <= i_tex_v;
        end
        if (i_cmd.ld_v2) begin
            r_p2   <= pin;
            r_uv2[0] <= i_tex_u;
            r_uv2[1] <= i_tex_v;
        end
    end

    // edge differences
    logic signed [DIFF_W-1:0] ea [3], eb [3], dp1 [3], dp2 [3];
    logic signed [DIFF_W-1:0] du1, dv1, du2, dv2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ea[i]  = delta(r_p0[i], r_p1[i]);
            eb[i]  = delta(r_p0[i], r_p2[i]);
            dp1[i] = delta(r_p1[i], r_p0[i]);
            dp2[i] = delta(r_p2[i], r_p0[i]);
        end
        du1 = delta(r_uv1[0], r_uv0[0]);
        dv1 = delta(r_uv1[1], r_uv0[1]);
        du2 = delta(r_uv2[0], r_uv0[0]);
        dv2 = delta(r_uv2[1], r_uv0[1]);
    end

    // product stage
    logic signed [PROD_W-1:0] r_m [14];

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_en) begin
            r_m[0]  <= PROD_W'(ea[2]) * PROD_W'(eb[1]);
            r_m[1]  <= PROD_W'(ea[1]) * PROD_W'(eb[2]);
            r_m[2]  <= PROD_W'(ea[0]) * PROD_W'(eb[2]);
            r_m[3]  <= PROD_W'(ea[2]) * PROD_W'(eb[0]);
            r_m[4]  <= PROD_W'(ea[1]) * PROD_W'(eb[0]);
            r_m[5]  <= PROD_W'(ea[0]) * PROD_W'(eb[1]);
            for (int i = 0; i < 3; i++) begin
                r_m[6+2*i] <= PROD_W'(dp1[i]) * PROD_W'(dv2);
                r_m[7+2*i] <= PROD_W'(dp2[i]) * PROD_W'(dv1);
            end
            r_m[12] <= PROD_W'(du1) * PROD_W'(dv2);
            r_m[13] <= PROD_W'(dv1) * PROD_W'(du2);
        end
    end

    // sum stage: negated cross, signed tangent, det check
    logic signed [VEC_W-1:0] r_cr [3], r_tg [3];
    logic signed [VEC_W-1:0] det;
    logic signed [VEC_W-1:0] tgd [3];

    always_comb begin
        det = VEC_W'(r_m[12]) - VEC_W'(r_m[13]);
        for (int i = 0; i < 3; i++) begin
            tgd[i] = VEC_W'(r_m[6+2*i]) - VEC_W'(r_m[7+2*i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            for (int i = 0; i < 3; i++) begin
                r_cr[i] <= VEC_W'(r_m[2*i]) - VEC_W'(r_m[2*i+1]);
                if (det == '0) r_tg[i] <= '0;
                else if (det < 0) r_tg[i] <= -tgd[i];
                else r_tg[i] <= tgd[i];
            end
        end
    end

    // normalizer: magnitudes and scaling
    logic             r_neg [3];
    logic [MAG_W-1:0] r_mag [3];
    logic [MAG_W-1:0] mx;
    logic signed [VEC_W-1:0] vin [3];
    logic [VEC_W-1:0] vabs [3];

    always_comb begin
        mx = r_mag[0];
        if (r_mag[1] > mx) mx = r_mag[1];
        if (r_mag[2] > mx) mx = r_mag[2];
        o_stat.vec_zero = (mx == '0);
        o_stat.in_range = (mx[MAG_W-1:31] == '0) && mx[30];
        for (int i = 0; i < 3; i++) begin
            vin[i]  = i_cmd.nrm_sel ? r_tg[i] : r_cr[i];
            vabs[i] = vin[i][VEC_W-1] ? VEC_W'(-vin[i]) : VEC_W'(vin[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nrm_load) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= vin[i][VEC_W-1];
                r_mag[i] <= vabs[i][MAG_W-1:0];
            end
        end else if (i_cmd.scale_en) begin
            for (int i = 0; i < 3; i++) begin
                if (mx[MAG_W-1:31] != '0) r_mag[i] <= r_mag[i] >> 1;
                else r_mag[i] <= r_mag[i] << 1;
            end
        end
    end

    // sum of squares, one component a cycle
    logic [SQ_W-1:0]  sq_op;
    logic [SUM_W-1:0] r_sum;

    assign sq_op = r_mag[i_cmd.sq_idx][SQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) begin
            r_sum <= ((i_cmd.sq_idx == 2'd0) ? '0 : r_sum)
                   + SUM_W'(SUM_W'(sq_op) * SUM_W'(sq_op));
        end
    end

    // integer square root, one result bit a cycle
    logic [SUM_W-1:0]  r_xs;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  s_t, s_trial;

    assign s_t     = {r_rem[REM_W-3:0], r_xs[SUM_W-1:SUM_W-2]};
    assign s_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_xs   <= r_sum;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_xs <= r_xs << 2;
            if (s_t >= s_trial) begin
                r_rem  <= s_t - s_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= s_t;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // three restoring dividers, one quotient bit a cycle each
    logic [DREM_W-1:0]    r_drem [3];
    logic [UNIT_BITS-1:0] r_dlow [3];
    logic [UNIT_BITS-1:0] r_q [3];
    logic [NUM_W-1:0]     num [3];
    logic [DREM_W:0]      dt [3];
    logic [DREM_W:0]      dden;

    always_comb begin
        dden = {1'b0, r_root};
        for (int i = 0; i < 3; i++) begin
            num[i] = (NUM_W'(r_mag[i][SQ_W-1:0]) << (UNIT_BITS-1))
                   + NUM_W'(r_root >> 1);
            dt[i]  = {r_drem[i], r_dlow[i][UNIT_BITS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.div_init) begin
                r_drem[i] <= DREM_W'(num[i] >> UNIT_BITS);
                r_dlow[i] <= num[i][UNIT_BITS-1:0];
                r_q[i]    <= '0;
            end else if (i_cmd.div_step) begin
                r_dlow[i] <= r_dlow[i] << 1;
                if (dt[i] >= dden) begin
                    r_drem[i] <= DREM_W'(dt[i] - dden);
                    r_q[i]    <= {r_q[i][UNIT_BITS-2:0], 1'b1};
                end else begin
                    r_drem[i] <= dt[i][DREM_W-1:0];
                    r_q[i]    <= {r_q[i][UNIT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // result registers
    logic [UNIT_BITS-1:0] r_nrm [3], r_tan [3];
    logic                 r_ndeg, r_tdeg;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.st_nrm) r_nrm[i] <= o_stat.vec_zero ? '0 : fmt(r_q[i], r_neg[i]);
            if (i_cmd.st_tan) r_tan[i] <= o_stat.vec_zero ? '0 : fmt(r_q[i], r_neg[i]);
        end
        if (i_cmd.st_nrm) r_ndeg <= o_stat.vec_zero;
        if (i_cmd.st_tan) r_tdeg <= o_stat.vec_zero;
    end

    assign o_normal_x  = r_nrm[0];
    assign o_normal_y  = r_nrm[1];
    assign o_normal_z  = r_nrm[2];
    assign o_tangent_x = r_tan[0];
    assign o_tangent_y = r_tan[1];
    assign o_tangent_z = r_tan[2];
    assign o_normal_degenerate  = r_ndeg;
    assign o_tangent_degenerate = r_tdeg;

endmodule

// File: design/tntg_ctrl.sv
// Sequencer: vertex phase, normalizer step control and result delivery.
module tntg_ctrl import tntg_pkg::*; #(
    parameter int UNIT_BITS = UNIT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_corner_index,
    output logic       o_last_of_triangle,
    output t_cmd       o_cmd,
    input  t_stat      i_stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_SUM, S_LOAD, S_SCALE, S_SQ, S_SQRT, S_DIV, S_STORE, S_OUT
    } t_state;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;
    localparam logic [1:0] LAST_CORNER = 2'd2;

    t_state     r_state;
    logic [1:0] r_phase;
    logic [5:0] r_cnt;
    logic       r_pass;
    logic       r_valid;
    logic [1:0] r_corner;
    logic       acc;

    assign acc = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_corner_index = r_corner;
    assign o_last_of_triangle = (r_corner == LAST_CORNER);

    // command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.nrm_sel = r_pass;
        o_cmd.sq_idx  = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.ld_v1 = (r_phase == PH_SECOND);
                    o_cmd.ld_v2 = (r_phase == PH_THIRD);
                    o_cmd.ld_v0 = (r_phase != PH_SECOND) && (r_phase != PH_THIRD);
                end
            end
            S_PROD:  o_cmd.prod_en = 1'b1;
            S_SUM:   o_cmd.sum_en = 1'b1;
            S_LOAD:  o_cmd.nrm_load = 1'b1;
            S_SCALE: o_cmd.scale_en = !i_stat.vec_zero && !i_stat.in_range;
            S_SQ:    o_cmd.sq_en = 1'b1;
            S_SQRT: begin
                o_cmd.sqrt_init = (r_cnt == '0);
                o_cmd.sqrt_step = (r_cnt != '0);
            end
            S_DIV: begin
                o_cmd.div_init = (r_cnt == '0);
                o_cmd.div_step = (r_cnt != '0);
            end
            S_STORE: begin
                o_cmd.st_nrm = !r_pass;
                o_cmd.st_tan = r_pass;
            end
            default: ;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_FIRST;
            r_cnt    <= '0;
            r_pass   <= 1'b0;
            r_valid  <= 1'b0;
            r_corner <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (r_phase == PH_THIRD) begin
                            r_phase <= PH_FIRST;
                            r_state <= S_PROD;
                        end else if (r_phase == PH_SECOND) begin
                            r_phase <= PH_THIRD;
                        end else begin
                            r_phase <= PH_SECOND;
                        end
                    end
                end
                S_PROD: r_state <= S_SUM;
                S_SUM: begin
                    r_pass  <= 1'b0;
                    r_state <= S_LOAD;
                end
                S_LOAD: r_state <= S_SCALE;
                S_SCALE: begin
                    r_cnt <= '0;
                    if (i_stat.vec_zero) r_state <= S_STORE;
                    else if (i_stat.in_range) r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_cnt == 6'd2) begin
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 6'(SQRT_STEPS)) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'(UNIT_BITS)) begin
                        r_cnt   <= '0;
                        r_state <= S_STORE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_STORE: begin
                    if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_valid  <= 1'b1;
                        r_corner <= '0;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_corner == LAST_CORNER) begin
                            r_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_corner <= r_corner + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: design/triangle_normal_tangent_gen_unit.sv
// Flat face normal and tangent generator, top level.
// The first two vertices of a triangle are each taken at once when offered. The third
// starts a run of the shared normalizer (1-bit-a-cycle square root and dividers, 0..30
// scaling shifts per vector); then three requests are offered, one per corner. No vertex
// is taken meanwhile.
// Synchronous active-low reset returns to the first vertex with no result pending.
module triangle_normal_tangent_gen_unit import tntg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int UNIT_BITS  = UNIT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic signed [COORD_BITS-1:0] i_tex_u,
    input  logic signed [COORD_BITS-1:0] i_tex_v,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [UNIT_BITS-1:0]  o_normal_x,
    output logic signed [UNIT_BITS-1:0]  o_normal_y,
    output logic signed [UNIT_BITS-1:0]  o_normal_z,
    output logic signed [UNIT_BITS-1:0]  o_tangent_x,
    output logic signed [UNIT_BITS-1:0]  o_tangent_y,
    output logic signed [UNIT_BITS-1:0]  o_tangent_z,
    output logic                         o_normal_degenerate,
    output logic                         o_tangent_degenerate,
    output logic [1:0]                   o_corner_index,
    output logic                         o_last_of_triangle
);

    t_cmd  cmd;
    t_stat stat;

    tntg_ctrl #(
        .UNIT_BITS(UNIT_BITS)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_corner_index     (o_corner_index),
        .o_last_of_triangle (o_last_of_triangle),
        .o_cmd              (cmd),
        .i_stat             (stat)
    );

    tntg_dp #(
        .COORD_BITS(COORD_BITS),
        .UNIT_BITS (UNIT_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_pos_x              (i_pos_x),
        .i_pos_y              (i_pos_y),
        .i_pos_z              (i_pos_z),
        .i_tex_u              (i_tex_u),
        .i_tex_v              (i_tex_v),
        .o_normal_x           (o_normal_x),
        .o_normal_y           (o_normal_y),
        .o_normal_z           (o_normal_z),
        .o_tangent_x          (o_tangent_x),
        .o_tangent_y          (o_tangent_y),
        .o_tangent_z          (o_tangent_z),
        .o_normal_degenerate  (o_normal_degenerate),
        .o_tangent_degenerate (o_tangent_degenerate)
    );

endmodule

// File: dv/tb_triangle_normal_tangent_gen_unit.sv
// Testbench for the flat face normal and tangent unit: random vertex stream, scoreboard check.
`timescale 1ns / 1ps

module tb_triangle_normal_tangent_gen_unit import tntg_pkg::*; ();

    localparam int CW = COORD_BITS_DEF;
    localparam int UW = UNIT_BITS_DEF;

    typedef struct packed {
        logic signed [UW-1:0] nx, ny, nz, tx, ty, tz;
        logic                 ndeg, tdeg;
        logic [1:0]           corner;
        logic                 last;
    } t_face;

    typedef logic signed [CW-1:0] t_coord;

    int errors = 0;

    // one line per mismatch
    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Scoreboard: holds the first two corners, predicts the three results per triangle.
    class face_scoreboard;
        int unsigned phase;
        t_coord      c0[5], c1[5];
        t_face       pending[$];

        function new();
            phase = 0;
        endfunction

        function automatic void to_unit(input longint v[3], output logic signed [UW-1:0] q[3],
                                        output bit is_zero);
            longint unsigned mag[3], mx, total, root, bitv, rem, half, r;
            bit neg[3];
            mx = 0;
            half = 64'd1 << (UW - 1);
            for (int i = 0; i < 3; i++) begin
                neg[i] = v[i] < 0;
                mag[i] = neg[i] ? -v[i] : v[i];
                if (mag[i] > mx) mx = mag[i];
            end
            is_zero = (mx == 0);
            for (int i = 0; i < 3; i++) q[i] = '0;
            if (is_zero) return;
            while (mx >= (64'd1 << 31)) begin
                mx >>= 1;
                for (int i = 0; i < 3; i++) mag[i] >>= 1;
            end
            while (mx < (64'd1 << 30)) begin
                mx <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            total = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            // bitwise integer square root
            root = 0;
            bitv = 64'd1 << 62;
            rem = total;
            while (bitv > rem) bitv >>= 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            for (int i = 0; i < 3; i++) begin
                r = (mag[i] * half + (root >> 1)) / root;
                if (r > half) r = half;
                if (!neg[i] && r == half) r = half - 1;
                q[i] = UW'(neg[i] ? -r : r);
            end
        endfunction

        // note one accepted vertex
        function automatic void note_vertex(t_coord v[5]);
            longint a[3], b[3], d1[3], d2[3], cr[3], tg[3];
            longint du1, dv1, du2, dv2, det;
            logic signed [UW-1:0] nq[3], tq[3];
            bit nz, tz;
            t_face f;
            if (phase == 1) begin
                c1 = v;
                phase = 2;
                return;
            end
            if (phase != 2) begin
                c0 = v;
                phase = 1;
                return;
            end
            phase = 0;
            for (int i = 0; i < 3; i++) begin
                a[i] = longint'(c0[i]) - longint'(c1[i]);
                b[i] = longint'(c0[i]) - longint'(v[i]);
                d1[i] = -a[i];
                d2[i] = -b[i];
            end
            cr[0] = -(a[1] * b[2] - a[2] * b[1]);
            cr[1] = -(a[2] * b[0] - a[0] * b[2]);
            cr[2] = -(a[0] * b[1] - a[1] * b[0]);
            to_unit(cr, nq, nz);
            du1 = longint'(c1[3]) - longint'(c0[3]);
            dv1 = longint'(c1[4]) - longint'(c0[4]);
            du2 = longint'(v[3]) - longint'(c0[3]);
            dv2 = longint'(v[4]) - longint'(c0[4]);
            det = du1 * dv2 - dv1 * du2;
            for (int i = 0; i < 3; i++) begin
                tg[i] = d1[i] * dv2 - d2[i] * dv1;
                if (det < 0) tg[i] = -tg[i];
            end
            if (det == 0) begin
                tz = 1;
                for (int i = 0; i < 3; i++) tq[i] = '0;
            end else begin
                to_unit(tg, tq, tz);
            end
            for (int k = 0; k < 3; k++) begin
                f = '{nq[0], nq[1], nq[2], tq[0], tq[1], tq[2], nz, tz, 2'(k), k == 2};
                pending.push_back(f);
            end
        endfunction

        // compare one accepted result with the oldest prediction
        task automatic check_face(t_face got);
            t_face w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result corner", got.corner, -1);
                return;
            end
            w = pending.pop_front();
            if (got.nx !== w.nx) report_mismatch("normal_x", got.nx, w.nx);
            if (got.ny !== w.ny) report_mismatch("normal_y", got.ny, w.ny);
            if (got.nz !== w.nz) report_mismatch("normal_z", got.nz, w.nz);
            if (got.tx !== w.tx) report_mismatch("tangent_x", got.tx, w.tx);
            if (got.ty !== w.ty) report_mismatch("tangent_y", got.ty, w.ty);
            if (got.tz !== w.tz) report_mismatch("tangent_z", got.tz, w.tz);
            if (got.ndeg !== w.ndeg) report_mismatch("normal_degenerate", got.ndeg, w.ndeg);
            if (got.tdeg !== w.tdeg) report_mismatch("tangent_degenerate", got.tdeg, w.tdeg);
            if (got.corner !== w.corner) report_mismatch("corner_index", got.corner, w.corner);
            if (got.last !== w.last) report_mismatch("last_of_triangle", got.last, w.last);
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_stall;
    t_coord               i_pos_x = '0, i_pos_y = '0, i_pos_z = '0, i_tex_u = '0, i_tex_v = '0;
    logic                 o_valid;
    logic                 i_stall = 0;
    logic signed [UW-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic signed [UW-1:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic                 o_normal_degenerate, o_tangent_degenerate;
    logic [1:0]           o_corner_index;
    logic                 o_last_of_triangle;

    triangle_normal_tangent_gen_unit dut (.*);

    face_scoreboard sb = new();
    bit             feed_done = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // mostly short gaps, sometimes long
    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one vertex request and hold it until taken
    task automatic send_vertex(t_coord v[5]);
        int g = gap_len();
        repeat (g) @(posedge i_clk) i_valid <= 0;
        @(posedge i_clk);
        i_valid <= 1;
        i_pos_x <= v[0]; i_pos_y <= v[1]; i_pos_z <= v[2];
        i_tex_u <= v[3]; i_tex_v <= v[4];
        do @(posedge i_clk); while (o_stall);
        sb.note_vertex(v);
        i_valid <= 0;
    endtask

    function automatic t_coord rnd_coord(int kind);
        case (kind)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 4000)) - 2000);
            2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return t_coord'($urandom) >>> $urandom_range(0, CW - 1);
        endcase
    endfunction

    task automatic send_triangle(t_coord p[3][5]);
        for (int k = 0; k < 3; k++) send_vertex(p[k]);
    endtask

    // stimulus
    initial begin
        t_coord tri_c[3][5];
        t_coord mx, mn;
        int kind;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: unit right triangle
        tri_c = '{'{0, 0, 0, 0, 0}, '{65536, 0, 0, 65536, 0}, '{0, 65536, 0, 0, 65536}};
        send_triangle(tri_c);
        // zero cross product (collinear) and zero det
        tri_c = '{'{1, 2, 3, 5, 5}, '{2, 4, 6, 5, 5}, '{3, 6, 9, 5, 5}};
        send_triangle(tri_c);
        // positive det, flipped winding
        tri_c = '{'{0, 0, 0, 0, 0}, '{0, 65536, 0, 65536, 0}, '{65536, 0, 0, 0, 65536}};
        send_triangle(tri_c);
        // extremes of every field
        tri_c = '{'{mn, mn, mn, mn, mn}, '{mx, mn, mx, mx, mn}, '{mn, mx, mx, mn, mx}};
        send_triangle(tri_c);
        tri_c = '{'{mx, mx, mx, mx, mx}, '{mn, mx, mn, mn, mx}, '{mx, mn, mn, mx, mn}};
        send_triangle(tri_c);
        // nonzero det but zero tangent: positions coincide
        tri_c = '{'{7, 7, 7, 0, 0}, '{7, 7, 7, 100, 0}, '{7, 7, 7, 0, 100}};
        send_triangle(tri_c);
        // single-axis normal, exact saturation case
        tri_c = '{'{0, 0, 0, 0, 0}, '{0, 0, 1, 0, 1}, '{0, 1, 0, 1, 0}};
        send_triangle(tri_c);

        // random triangles
        for (int t = 0; t < 96; t++) begin
            kind = $urandom_range(0, 3);
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 5; j++)
                    tri_c[k][j] = rnd_coord(kind);
            // occasional degenerate: repeat a corner or share UVs
            if ($urandom_range(0, 9) == 0) tri_c[2][0:2] = tri_c[1][0:2];
            if ($urandom_range(0, 9) == 0) tri_c[2][3:4] = tri_c[0][3:4];
            send_triangle(tri_c);
        end

        feed_done = 1;
    end

    // result side: random stall, check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_face('{o_normal_x, o_normal_y, o_normal_z, o_tangent_x, o_tangent_y,
                            o_tangent_z, o_normal_degenerate, o_tangent_degenerate,
                            o_corner_index, o_last_of_triangle});
    end

    initial begin
        int g;
        while (1) begin
            @(posedge i_clk);
            i_stall <= 0;
            g = gap_len();
            if ($urandom_range(0, 3) == 0) g = 0;
            repeat (g) @(posedge i_clk) i_stall <= 1;
        end
    end

    // end of run
    initial begin
        wait (feed_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && sb.pending.size() == 0)
            $display("triangle_normal_tangent_gen_unit: match");
        else
            $display("triangle_normal_tangent_gen_unit: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("triangle_normal_tangent_gen_unit: mismatch");
        $finish;
    end
endmodule

// File: sim.f
design/tntg_pkg.sv
design/tntg_dp.sv
design/tntg_ctrl.sv
design/triangle_normal_tangent_gen_unit.sv
dv/tb_triangle_normal_tangent_gen_unit.sv
